// ===== rtl/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int MAX_WIDTH  = 32;
    localparam int BCD_DIGITS = MAX_WIDTH / 3 + 1;
    localparam int DIGIT_IDX_W = $clog2(BCD_DIGITS);
    localparam int BIT_CNT_W  = $clog2(MAX_WIDTH);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [2:0] MODE_U8    = 3'd0;
    localparam logic [2:0] MODE_U16   = 3'd1;
    localparam logic [2:0] MODE_U32   = 3'd2;
    localparam logic [2:0] MODE_S8    = 3'd3;
    localparam logic [2:0] MODE_S16   = 3'd4;
    localparam logic [2:0] MODE_S32   = 3'd5;
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

endpackage

// ===== rtl/itoa_dabble.sv =====
// ----------------------------------------------------------------------------
// itoa_dabble
// One shift-add-3 step of the binary to BCD conversion.
// ----------------------------------------------------------------------------
module itoa_dabble (
    input  itoa_pkg::bcd_t bcd_in,
    input  logic           bit_in,
    output itoa_pkg::bcd_t bcd_out
);

    itoa_pkg::bcd_t adj;

    always_comb begin
        for (int i = 0; i < itoa_pkg::BCD_DIGITS; i++) begin
            adj[i] = (bcd_in[i] >= 4'd5) ? bcd_in[i] + 4'd3 : bcd_in[i];
        end
    end

    assign bcd_out = {adj[itoa_pkg::BCD_DIGITS-1][2:0],
                      adj[itoa_pkg::BCD_DIGITS-2:0], bit_in};

endmodule

// ===== rtl/integer_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii
// Converts an 8, 16 or 32 bit integer, signed or unsigned, to decimal ASCII.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// s_       in   tvalid/tready      tdata: value[31:0]; tuser: mode[2:0]
// m_       out  tvalid/tready      tdata: char_code[7:0]; tlast: last
//
// A request is accepted while idle and takes MAX_WIDTH (32) shift-add-3 steps
// through the shared dabble unit. A minus sign for a negative value comes first,
// then one BCD digit slot at a time (11, leading zero slots skipped at one per
// cycle), from the most significant slot down.
// s_tready is high only while idle. Output stalls hold the emitter.
// aresetn is synchronous, active low, and clears the control state.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [2:0]  s_tuser,   // mode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // char_code[7:0]
    output logic        m_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam int MW = itoa_pkg::MAX_WIDTH;

    logic [1:0]                       state_reg, state_next;
    logic [MW-1:0]                    mag_reg, mag_next;
    itoa_pkg::bcd_t                   bcd_reg, bcd_next, bcd_step;
    logic [itoa_pkg::BIT_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [itoa_pkg::DIGIT_IDX_W-1:0] idx_reg, idx_next;
    logic                             neg_reg, neg_next;
    logic                             started_reg, started_next;
    logic                             out_valid_reg, out_valid_next;
    logic [7:0]                       out_char_reg, out_char_next;
    logic                             out_last_reg, out_last_next;

    logic [31:0] raw;
    logic [2:0]  mode;
    logic [31:0] mask;
    logic        is_signed;
    logic [31:0] masked;
    logic        sign_bit;
    logic [31:0] in_mag;
    logic [3:0]  cur_digit;
    logic        can_load;

    assign raw  = s_tdata;
    assign mode = s_tuser;

    always_comb begin
        case (mode)
            itoa_pkg::MODE_U8:  begin mask = 32'h0000_00FF; is_signed = 1'b0; end
            itoa_pkg::MODE_U16: begin mask = 32'h0000_FFFF; is_signed = 1'b0; end
            itoa_pkg::MODE_S8:  begin mask = 32'h0000_00FF; is_signed = 1'b1; end
            itoa_pkg::MODE_S16: begin mask = 32'h0000_FFFF; is_signed = 1'b1; end
            itoa_pkg::MODE_S32: begin mask = 32'hFFFF_FFFF; is_signed = 1'b1; end
            default:            begin mask = 32'hFFFF_FFFF; is_signed = 1'b0; end
        endcase
    end

    assign masked = raw & mask;

    always_comb begin
        case (mode)
            itoa_pkg::MODE_S8:  sign_bit = masked[7];
            itoa_pkg::MODE_S16: sign_bit = masked[15];
            default:            sign_bit = masked[31];
        endcase
    end

    assign in_mag = (is_signed && sign_bit) ? ((~masked + 32'd1) & mask) : masked;

    itoa_dabble u_dabble (
        .bcd_in  (bcd_reg),
        .bit_in  (mag_reg[MW-1]),
        .bcd_out (bcd_step)
    );

    assign cur_digit = bcd_reg[idx_reg];
    assign can_load  = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        neg_next       = neg_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mag_next     = MW'(in_mag);
                    neg_next     = is_signed && sign_bit;
                    bcd_next     = '0;
                    cnt_next     = itoa_pkg::BIT_CNT_W'(MW - 1);
                    started_next = 1'b0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next = bcd_step;
                mag_next = {mag_reg[MW-2:0], 1'b0};
                if (cnt_reg == '0) begin
                    idx_next   = itoa_pkg::DIGIT_IDX_W'(itoa_pkg::BCD_DIGITS - 1);
                    state_next = ST_EMIT;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_EMIT: begin
                if (neg_reg) begin
                    if (can_load) begin
                        out_valid_next = 1'b1;
                        out_char_next  = itoa_pkg::CH_MINUS;
                        out_last_next  = 1'b0;
                        neg_next       = 1'b0;
                    end
                end else if (!started_reg && cur_digit == 4'd0 && idx_reg != '0) begin
                    idx_next = idx_reg - 1'b1;
                end else if (can_load) begin
                    out_valid_next = 1'b1;
                    out_char_next  = itoa_pkg::CH_ZERO + {4'd0, cur_digit};
                    out_last_next  = (idx_reg == '0);
                    started_next   = 1'b1;
                    if (idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            neg_reg       <= 1'b0;
            started_reg   <= 1'b0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            neg_reg       <= neg_next;
            started_reg   <= started_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for integer_to_decimal_ascii. Each request carries a value and a
// width/sign mode. A local predictor builds the expected character run, and
// every character accepted on m_ is checked against it in order. The sender
// works in random bursts and the receiver stalls on its own pattern, with one
// long output hold-off that backs the converter up into its input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          DRAIN_CYCLES = 80;
    localparam int          MAX_REPORTS = 40;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } ascii_char_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    ascii_char_t expected_chars[$];
    int          err_count = 0;
    int          req_count = 0;
    int          char_count = 0;
    int unsigned cycle_count = 0;
    int          burst_left = 0;
    bit          no_gaps = 1'b0;
    bit          rx_always = 1'b0;
    int          hold_left = 0;

    integer_to_decimal_ascii u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("integer_to_decimal_ascii test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("MISMATCH @%0d: %s", cycle_count, msg);
    endtask

    // Expected decimal text of one request, pushed one character at a time.
    function automatic void predict_text(input logic [31:0] value, input logic [2:0] mode);
        int          width;
        bit          is_signed;
        logic [63:0] mask;
        logic [63:0] mag;
        bit          neg;
        logic [7:0]  digits[12];
        int          nd;
        width = 32;
        is_signed = 1'b0;
        neg = 1'b0;
        nd = 0;
        case (mode)
            itoa_pkg::MODE_U8:  width = 8;
            itoa_pkg::MODE_U16: width = 16;
            itoa_pkg::MODE_S8:  begin width = 8;  is_signed = 1'b1; end
            itoa_pkg::MODE_S16: begin width = 16; is_signed = 1'b1; end
            itoa_pkg::MODE_S32: begin width = 32; is_signed = 1'b1; end
            default:            width = 32;
        endcase
        mask = (64'd1 << width) - 64'd1;
        mag = {32'd0, value} & mask;
        if (is_signed && mag[width-1]) begin
            neg = 1'b1;
            mag = (~mag + 64'd1) & mask;
        end
        if (mag == 64'd0) begin
            expected_chars.push_back('{char_code: itoa_pkg::CH_ZERO, last: 1'b1});
            return;
        end
        while (mag != 64'd0) begin
            digits[nd] = itoa_pkg::CH_ZERO + 8'(mag % 64'd10);
            mag = mag / 64'd10;
            nd++;
        end
        if (neg)
            expected_chars.push_back('{char_code: itoa_pkg::CH_MINUS, last: 1'b0});
        for (int i = nd - 1; i >= 0; i--)
            expected_chars.push_back('{char_code: digits[i], last: (i == 0)});
    endfunction

    // Offer one request and hold it until accepted; valid stays high afterwards.
    task automatic send_request(input logic [31:0] value, input logic [2:0] mode);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = value;
        s_tuser = mode;
        do @(posedge aclk); while (!s_tready);
        predict_text(value, mode);
        req_count++;
    endtask

    task automatic idle_cycles(input int n);
        @(negedge aclk);
        s_tvalid = 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    // Sender side: bursts of random length separated by random gaps.
    task automatic issue(input logic [31:0] value, input logic [2:0] mode);
        send_request(value, mode);
        if (!no_gaps) begin
            if (burst_left > 0)
                burst_left--;
            else begin
                burst_left = $urandom_range(0, 6);
                idle_cycles($urandom_range(1, 60));
            end
        end
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] p;
        p = 32'd1;
        case ($urandom_range(0, 6))
            0: return $urandom_range(0, 20);
            1: begin
                repeat ($urandom_range(0, 9)) p = p * 32'd10;
                return p + $urandom_range(0, 2) - 32'd1;
            end
            2: return {24'($urandom), 8'h80} + $urandom_range(0, 2) - 32'd1;
            3: return {16'($urandom), 16'h8000} + $urandom_range(0, 2) - 32'd1;
            4: return 32'h8000_0000 + $urandom_range(0, 2) - 32'd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_mode();
        if ($urandom_range(0, 15) == 0)
            return 3'($urandom_range(itoa_pkg::MODE_RSVD6, itoa_pkg::MODE_RSVD7));
        return 3'($urandom_range(itoa_pkg::MODE_U8, itoa_pkg::MODE_S32));
    endfunction

    always @(posedge aclk) begin
        ascii_char_t exp_c;
        if (aresetn && m_tvalid && m_tready) begin
            char_count++;
            if (expected_chars.size() == 0)
                report_mismatch($sformatf("unexpected character 0x%02h", m_tdata));
            else begin
                exp_c = expected_chars.pop_front();
                if (m_tdata !== exp_c.char_code)
                    report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                              m_tdata, exp_c.char_code));
                if (m_tlast !== exp_c.last)
                    report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
                                              m_tlast, exp_c.last, exp_c.char_code));
            end
        end
    end

    // Receiver stall pattern, with an optional long hold-off.
    initial begin
        int rx_mode;
        int rx_left;
        rx_mode = 0;
        rx_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (rx_always) begin
                m_tready = 1'b1;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = $urandom_range(0, 2);
                    rx_left = $urandom_range(10, 150);
                end
                rx_left--;
                case (rx_mode)
                    0: m_tready = 1'b1;
                    1: m_tready = ($urandom_range(0, 3) != 0);
                    default: m_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic test_directed();
        issue(32'h0000_0000, itoa_pkg::MODE_U8);
        issue(32'h0000_00FF, itoa_pkg::MODE_U8);
        issue(32'hFFFF_FF00, itoa_pkg::MODE_U8);
        issue(32'h0000_0000, itoa_pkg::MODE_U16);
        issue(32'hABCD_FFFF, itoa_pkg::MODE_U16);
        issue(32'h0000_0000, itoa_pkg::MODE_U32);
        issue(32'hFFFF_FFFF, itoa_pkg::MODE_U32);
        issue(32'd1000000000, itoa_pkg::MODE_U32);
        issue(32'd9, itoa_pkg::MODE_U32);
        issue(32'h0000_0080, itoa_pkg::MODE_S8);
        issue(32'h0000_007F, itoa_pkg::MODE_S8);
        issue(32'hFFFF_FFFF, itoa_pkg::MODE_S8);
        issue(32'h1234_5600, itoa_pkg::MODE_S8);
        issue(32'h0000_8000, itoa_pkg::MODE_S16);
        issue(32'h0000_7FFF, itoa_pkg::MODE_S16);
        issue(32'h5555_FFFF, itoa_pkg::MODE_S16);
        issue(32'h8000_0000, itoa_pkg::MODE_S32);
        issue(32'h7FFF_FFFF, itoa_pkg::MODE_S32);
        issue(32'hFFFF_FFFF, itoa_pkg::MODE_S32);
        issue(32'h0000_0000, itoa_pkg::MODE_S32);
        issue(32'hFFFF_FFFF, itoa_pkg::MODE_RSVD6);
        issue(32'd1234567890, itoa_pkg::MODE_RSVD7);
        issue(32'h8000_0000, itoa_pkg::MODE_RSVD7);
    endtask

    task automatic test_random_mix();
        repeat (200) issue(pick_value(), pick_mode());
    endtask

    task automatic test_output_holdoff();
        hold_left = 400;
        repeat (20) issue(pick_value(), pick_mode());
    endtask

    task automatic test_back_to_back();
        no_gaps = 1'b1;
        rx_always = 1'b1;
        repeat (40) send_request(pick_value(), pick_mode());
        no_gaps = 1'b0;
        rx_always = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_mix();
        test_output_holdoff();
        test_back_to_back();

        @(negedge aclk);
        s_tvalid = 1'b0;
        rx_always = 1'b1;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d requests and %0d characters across all eight mode codes,",
                 req_count, char_count);
        $display("with bursty input, random output stalls and one long output hold-off.");
        if (err_count == 0)
            $display("integer_to_decimal_ascii test passed");
        else
            $display("integer_to_decimal_ascii test failed");
        $finish;
    end

endmodule
